// ----- hw/rtl/range_add_range_sum_tree_core_macros.svh -----
// Assertion macros used by the checker file.
`ifndef RANGE_ADD_RANGE_SUM_TREE_CORE_MACROS_SVH
`define RANGE_ADD_RANGE_SUM_TREE_CORE_MACROS_SVH

// Checked on every edge, reset included.
`define RAST_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("rast: check failed");

// Checked only outside reset.
`define RAST_ASSERT_NEXT_RUN(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rast: check failed");

`endif

// ----- hw/rtl/rast_pkg.sv -----
package rast_pkg;

   localparam int POSITIONS = 1024;
   localparam int LEVELS    = $clog2(POSITIONS);
   localparam int NODES     = 2 * POSITIONS;
   localparam int NODE_W    = LEVELS + 1;
   localparam int LEN_W     = LEVELS + 1;
   localparam int DEPTH_W   = $clog2(LEVELS + 1);
   localparam int POS_W     = 11;
   localparam int ADD_W     = 16;
   localparam int SUM_W     = 48;
   localparam int CMD_W     = 2;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   typedef logic [LEVELS-1:0]  pos_type;
   typedef logic [NODE_W-1:0]  node_type;
   typedef logic [LEN_W-1:0]   len_type;
   typedef logic [DEPTH_W-1:0] depth_type;
   typedef logic [SUM_W-1:0]   sum_type;

   localparam sum_type SUM_MAX = '1;

   typedef struct packed {
      logic     valid;
      logic     full;
      node_type node;
      len_type  len;
   } visit_type;

   function automatic sum_type sat_add(input sum_type a, input sum_type b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
   endfunction

   function automatic sum_type sat_mul(input sum_type v, input len_type n);
      logic [SUM_W+LEN_W-1:0] p;
      p = {{LEN_W{1'b0}}, v} * {{SUM_W{1'b0}}, n};
      return (|p[SUM_W+LEN_W-1:SUM_W]) ? SUM_MAX : p[SUM_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/rast_node_geom.sv -----
// Picks the candidate node for (depth, slot): slots 0/1 are the children of the
// node holding the low end, slots 2/3 those of the node holding the high end.
module rast_node_geom (
   input  rast_pkg::pos_type   lo0,
   input  rast_pkg::pos_type   hi0,
   input  rast_pkg::depth_type depth,
   input  logic [1:0]          slot,
   output rast_pkg::visit_type visit
);
   import rast_pkg::*;

   depth_type shc, shp;
   pos_type   pl, ph, off;
   len_type   lo_w, hi_w, pl_l, pl_r1, ph_l, ph_r1, cl, cr1, cr, lo_max, hi_min;
   logic      part_l, part_h, par_ok;

   always_comb begin
      shc   = depth_type'(LEVELS) - depth;
      shp   = shc + depth_type'(1);
      lo_w  = {1'b0, lo0};
      hi_w  = {1'b0, hi0};
      pl    = lo0 >> shp;
      ph    = hi0 >> shp;
      pl_l  = {1'b0, pl} << shp;
      pl_r1 = ({1'b0, pl} + len_type'(1)) << shp;
      ph_l  = {1'b0, ph} << shp;
      ph_r1 = ({1'b0, ph} + len_type'(1)) << shp;
      // parent partly covered: its children must be looked at
      part_l = (pl_l < lo_w) || ((pl_r1 - len_type'(1)) > hi_w);
      part_h = (ph_l < lo_w) || ((ph_r1 - len_type'(1)) > hi_w);

      unique case (slot)
         2'd0: begin
            off    = {pl[LEVELS-2:0], 1'b0};
            par_ok = part_l;
         end
         2'd1: begin
            off    = {pl[LEVELS-2:0], 1'b1};
            par_ok = part_l;
         end
         2'd2: begin
            off    = {ph[LEVELS-2:0], 1'b0};
            par_ok = part_h && (ph != pl);
         end
         default: begin
            off    = {ph[LEVELS-2:0], 1'b1};
            par_ok = part_h && (ph != pl);
         end
      endcase

      if (depth == '0) begin
         off    = '0;
         par_ok = (slot == 2'd0);
      end

      cl     = {1'b0, off} << shc;
      cr1    = ({1'b0, off} + len_type'(1)) << shc;
      cr     = cr1 - len_type'(1);
      lo_max = (cl > lo_w) ? cl : lo_w;
      hi_min = (cr < hi_w) ? cr : hi_w;

      visit.valid = par_ok && !(cr < lo_w) && !(cl > hi_w);
      visit.full  = (cl >= lo_w) && (cr <= hi_w);
      visit.node  = (node_type'(1) << depth) | node_type'(off);
      visit.len   = hi_min - lo_max + len_type'(1);
   end

endmodule

// ----- hw/rtl/range_add_range_sum_tree_core.sv -----
// Channel | Dir | Beat fields                                   | Handshake
// req     | in  | cmd, range_low, range_high, addend            | req_valid / req_ready
// rsp     | out | range_sum                                     | rsp_valid / rsp_ready
// csr     | in  | positions_in_use (wr_data)                    | csr_wr_en, no wait
//
// Add/query visit at most 39 nodes (about four per level).
//   The walk steps through 41 candidate slots (root, then four per level); each
//   visited node costs a read, a multiply and a write-back (add) or accumulate (query) step.
// Clear: the 2048-entry sweep, one entry per cycle, then the beat and idle.
// Reset starts the same clearing pass; req_ready stays low meanwhile.
// One beat in flight; a new beat is taken while the last result waits on rsp.
module range_add_range_sum_tree_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [rast_pkg::CMD_W-1:0]  req_cmd,
   input  logic [rast_pkg::POS_W-1:0]  req_range_low,
   input  logic [rast_pkg::POS_W-1:0]  req_range_high,
   input  logic [rast_pkg::ADD_W-1:0]  req_addend,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rast_pkg::SUM_W-1:0]  rsp_range_sum,
   input  logic                        csr_wr_en,
   input  logic [rast_pkg::POS_W-1:0]  csr_wr_data
);
   import rast_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_VISIT = 6'b000100,
      ST_MUL   = 6'b001000,
      ST_ACC   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   // node word: pending add owed to the whole subtree, and subtree sum
   // including every add that reached this node
   typedef struct packed {
      sum_type tag;
      sum_type total;
   } word_type;

   state_type   state_ff, state_in;
   logic [POS_W-1:0] piu_ff, piu_in;
   pos_type     lo0_ff, lo0_in, hi0_ff, hi0_in;
   logic        is_add_ff, is_add_in;
   logic [ADD_W-1:0] addend_ff, addend_in;
   depth_type   depth_ff, depth_in;
   logic [1:0]  slot_ff, slot_in;
   node_type    node_ff, node_in;
   logic        full_ff, full_in;
   len_type     len_ff, len_in;
   sum_type     prod_ff, prod_in;
   sum_type     acc_ff, acc_in;
   node_type    sweep_ff, sweep_in;
   logic        clr_rsp_ff, clr_rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   sum_type     rsp_sum_ff, rsp_sum_in;

   word_type    mem [NODES];
   word_type    rd_ff;
   logic        mem_we, mem_re;
   node_type    mem_waddr;
   word_type    mem_wdata;

   visit_type   visit;
   logic [POS_W-1:0] lo_c, hi_c, lo_m1, hi_m1;
   logic        empty;
   depth_type   step_depth;
   logic [1:0]  step_slot;
   logic        step_last;
   sum_type     addend_ext;

   rast_node_geom u_geom (
      .lo0   (lo0_ff),
      .hi0   (hi0_ff),
      .depth (depth_ff),
      .slot  (slot_ff),
      .visit (visit)
   );

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;
   assign addend_ext    = {{(SUM_W-ADD_W){1'b0}}, addend_ff};

   // range clipping: low 0 means 1, high capped at positions in use
   always_comb begin
      lo_c  = (req_range_low == '0) ? POS_W'(1) : req_range_low;
      hi_c  = (req_range_high > piu_ff) ? piu_ff : req_range_high;
      empty = (lo_c > hi_c);
      lo_m1 = lo_c - POS_W'(1);
      hi_m1 = hi_c - POS_W'(1);
   end

   // walk order: root, then four slots per level
   always_comb begin
      step_last = (depth_ff == depth_type'(LEVELS)) && (slot_ff == 2'd3);
      if ((slot_ff == 2'd3) || (depth_ff == '0)) begin
         step_depth = depth_ff + depth_type'(1);
         step_slot  = 2'd0;
      end else begin
         step_depth = depth_ff;
         step_slot  = slot_ff + 2'd1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      piu_in       = piu_ff;
      lo0_in       = lo0_ff;
      hi0_in       = hi0_ff;
      is_add_in    = is_add_ff;
      addend_in    = addend_ff;
      depth_in     = depth_ff;
      slot_in      = slot_ff;
      node_in      = node_ff;
      full_in      = full_ff;
      len_in       = len_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      sweep_in     = sweep_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_in   = rsp_sum_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = node_ff;
      mem_wdata    = rd_ff;

      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            piu_in = POS_W'(1);
         end else if (csr_wr_data > POS_W'(POSITIONS)) begin
            piu_in = POS_W'(POSITIONS);
         end else begin
            piu_in = csr_wr_data;
         end
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '0;
            sweep_in  = sweep_ff + node_type'(1);
            acc_in    = '0;
            if (sweep_ff == node_type'(NODES - 1)) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               acc_in     = '0;
               depth_in   = '0;
               slot_in    = 2'd0;
               is_add_in  = (req_cmd == CMD_ADD);
               addend_in  = req_addend;
               lo0_in     = lo_m1[LEVELS-1:0];
               hi0_in     = hi_m1[LEVELS-1:0];
               if (req_cmd == CMD_CLEAR) begin
                  sweep_in   = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = ST_CLEAR;
               end else if (((req_cmd == CMD_ADD) || (req_cmd == CMD_QUERY)) && !empty) begin
                  state_in = ST_VISIT;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_VISIT: begin
            if (visit.valid) begin
               mem_re   = 1'b1;
               node_in  = visit.node;
               full_in  = visit.full;
               len_in   = visit.len;
               state_in = ST_MUL;
            end else begin
               depth_in = step_depth;
               slot_in  = step_slot;
               state_in = step_last ? ST_DONE : ST_VISIT;
            end
         end
         ST_MUL: begin
            // add: addend over the overlap; query: pending add over the overlap
            prod_in  = sat_mul(is_add_ff ? addend_ext : rd_ff.tag, len_ff);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (is_add_ff) begin
               mem_we          = 1'b1;
               mem_wdata.total = sat_add(rd_ff.total, prod_ff);
               mem_wdata.tag   = full_ff ? sat_add(rd_ff.tag, addend_ext) : rd_ff.tag;
            end else begin
               acc_in = sat_add(acc_ff, full_ff ? rd_ff.total : prod_ff);
            end
            // write lands before the next read, which is always another node
            depth_in = step_depth;
            slot_in  = step_slot;
            state_in = step_last ? ST_DONE : ST_VISIT;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         piu_ff       <= POS_W'(POSITIONS);
         sweep_ff     <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         piu_ff       <= piu_in;
         sweep_ff     <= sweep_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo0_ff     <= lo0_in;
      hi0_ff     <= hi0_in;
      is_add_ff  <= is_add_in;
      addend_ff  <= addend_in;
      depth_ff   <= depth_in;
      slot_ff    <= slot_in;
      node_ff    <= node_in;
      full_ff    <= full_in;
      len_ff     <= len_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   // node RAM, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[visit.node];
      end
   end

endmodule

// ----- hw/rtl/rast_checker.sv -----
`include "range_add_range_sum_tree_core_macros.svh"

module rast_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [rast_pkg::SUM_W-1:0] rsp_range_sum
);

   // reset starts the clearing pass: no beat out, none taken
   `RAST_ASSERT_NEXT(a_reset_quiet, reset, !rsp_valid && !req_ready)

   // one beat at a time through the walk
   `RAST_ASSERT_NEXT_RUN(a_busy_after_take, req_valid && req_ready, !req_ready)

   `RAST_ASSERT_NEXT_RUN(a_rsp_hold, rsp_valid && !rsp_ready,
                         rsp_valid && $stable(rsp_range_sum))

endmodule

bind range_add_range_sum_tree_core rast_checker u_rast_checker (.*);

// ----- test/range_add_range_sum_tree_core_tb.sv -----
`timescale 1ns / 1ps

// Checks the range-add / range-sum tree against a flat array of counters.
// The tree's lazy adds must always agree with plain per-position sums,
// clipped to the active position count and saturated at the sum width.
module range_add_range_sum_tree_core_tb;
   import rast_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int RANDOM_PER_PHASE = 125;

   // Counter-array model of the tree plus the queue of sums still owed.
   class range_sum_board;
      logic [63:0] counter [1:POSITIONS];
      int unsigned active_positions;
      sum_type sums_owed[$];
      int errors;

      function new();
         foreach (counter[i]) counter[i] = '0;
         active_positions = POSITIONS;
         errors = 0;
      endfunction

      function void set_positions(logic [POS_W-1:0] value);
         if (value == 0) active_positions = 1;
         else if (value > POSITIONS) active_positions = POSITIONS;
         else active_positions = value;
      endfunction

      function void note_beat(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] low,
                              logic [POS_W-1:0] high, logic [ADD_W-1:0] addend);
         int unsigned lo, hi;
         logic [63:0] total;
         lo = (low == 0) ? 1 : low;
         hi = (high > active_positions) ? active_positions : high;
         total = '0;
         case (cmd)
            CMD_CLEAR: foreach (counter[i]) counter[i] = '0;
            CMD_ADD: if (lo <= hi) for (int p = lo; p <= hi; p++)
               counter[p] += addend;
            CMD_QUERY: if (lo <= hi) for (int p = lo; p <= hi; p++)
               total += counter[p];
            default: ;
         endcase
         if (total > {16'd0, SUM_MAX}) total = {16'd0, SUM_MAX};
         sums_owed = {sums_owed, total[SUM_W-1:0]};
      endfunction

      function void check_sum(sum_type got);
         sum_type want;
         if (sums_owed.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual sum %0d", $time, got);
            errors++;
            return;
         end
         want = sums_owed.pop_front();
         if (got !== want) begin
            $display("%0t: range_sum mismatch, expected %0d, actual %0d", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid, req_ready;
   logic [CMD_W-1:0] req_cmd;
   logic [POS_W-1:0] req_range_low, req_range_high;
   logic [ADD_W-1:0] req_addend;
   logic rsp_valid, rsp_ready;
   logic [SUM_W-1:0] rsp_range_sum;
   logic csr_wr_en;
   logic [POS_W-1:0] csr_wr_data;

   range_sum_board board = new();
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   bit long_hold_request = 0;
   int unsigned cycle_count = 0;

   range_add_range_sum_tree_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_range_low(req_range_low),
      .req_range_high(req_range_high),
      .req_addend(req_addend),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_range_sum(rsp_range_sum),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Watchdog: the slowest legal run is far below this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Result side: check every accepted beat, then pick next ready.
   // A long hold is counted here so the block fills and back-pressures req.
   int hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) board.check_sum(rsp_range_sum);
         if (long_hold_request) begin
            hold_left = 400;
            long_hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // One request beat; valid stays up between back-to-back beats.
   task automatic send_beat(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] low,
                            logic [POS_W-1:0] high, logic [ADD_W-1:0] addend);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_range_low  <= low;
      req_range_high <= high;
      req_addend     <= addend;
      do @(posedge clock); while (!req_ready);
      board.note_beat(cmd, low, high, addend);
   endtask

   // Sender quiet until every owed sum is back; block is then idle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.sums_owed.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_positions(logic [POS_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_positions(value);
      @(posedge clock);
   endtask

   // Mostly well-formed adds and queries inside the active range;
   // the rest are raw 11-bit endpoints, clears and the unused command.
   task automatic random_beat();
      int pick;
      int unsigned a, b, lim;
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] low, high;
      pick = $urandom_range(99);
      lim = board.active_positions;
      if (pick < 2) cmd = CMD_CLEAR;
      else if (pick < 5) cmd = CMD_UNUSED;
      else if (pick < 50) cmd = CMD_ADD;
      else cmd = CMD_QUERY;
      if ($urandom_range(99) < 80) begin
         a = $urandom_range(1, lim);
         b = $urandom_range(1, lim);
         low  = POS_W'((a < b) ? a : b);
         high = POS_W'((a < b) ? b : a);
      end else begin
         low  = POS_W'($urandom);
         high = POS_W'($urandom);
      end
      send_beat(cmd, low, high, ADD_W'($urandom));
   endtask

   initial begin
      int unsigned phase_limits [6] = '{1, 0, 37, 1023, 2, 2047};
      int sent;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = CMD_CLEAR;
      req_range_low  = '0;
      req_range_high = '0;
      req_addend  = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_positions(11'd1024);
      // directed: extremes, every command, clipping and empty ranges
      send_beat(CMD_QUERY, 11'd1, 11'd1024, 16'd0);
      send_beat(CMD_ADD, 11'd1, 11'd1024, 16'hFFFF);
      send_beat(CMD_QUERY, 11'd1, 11'd1024, 16'd0);
      send_beat(CMD_ADD, 11'd0, 11'd2047, 16'd1);
      send_beat(CMD_QUERY, 11'd0, 11'd2047, 16'hFFFF);
      send_beat(CMD_ADD, 11'd1, 11'd1, 16'd7);
      send_beat(CMD_ADD, 11'd1024, 11'd1024, 16'd9);
      send_beat(CMD_QUERY, 11'd1, 11'd1, 16'd0);
      send_beat(CMD_QUERY, 11'd1024, 11'd1024, 16'd0);
      send_beat(CMD_ADD, 11'd600, 11'd5, 16'd500);
      send_beat(CMD_QUERY, 11'd600, 11'd5, 16'd0);
      send_beat(CMD_ADD, 11'd1500, 11'd2047, 16'd3);
      send_beat(CMD_QUERY, 11'd1025, 11'd2047, 16'd0);
      send_beat(CMD_UNUSED, 11'd1, 11'd1024, 16'hFFFF);
      send_beat(CMD_QUERY, 11'd512, 11'd513, 16'd0);
      send_beat(CMD_CLEAR, 11'd1, 11'd1024, 16'd0);
      send_beat(CMD_QUERY, 11'd1, 11'd1024, 16'd0);
      send_beat(CMD_ADD, 11'd300, 11'd700, 16'h8000);
      send_beat(CMD_QUERY, 11'd1, 11'd1024, 16'd0);
      drain();

      // Shrinking the range keeps counters above it; growing shows them again.
      sent = 0;
      foreach (phase_limits[ph]) begin
         write_positions(POS_W'(phase_limits[ph]));
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            if (sent < 250) begin
               tx_idle_pct = 35;
               rx_idle_pct = 78;
            end else if (sent < 500) begin
               tx_idle_pct = 78;
               rx_idle_pct = 35;
            end else begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
            if (ph == 3 && k == 10) long_hold_request = 1;
            if (ph == 4 && k == 60) drain();
            random_beat();
            sent++;
         end
         drain();
      end

      if (board.errors == 0 && board.sums_owed.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
